### hw/rtl/assert_macros.svh
// Assertion macros shared by the bitrate monitor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is active.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/swbm_pkg.sv
// Package of the sliding window bitrate monitor: widths, register indexes, states.
// Depends on nothing; used by the divider and the top level.
package swbm_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam int IN_W   = 24;
  localparam int SIZE_W = IN_W + 3;
  localparam int SUM_W  = 37;

  localparam int FPS_W  = 7;
  localparam int PER_W  = 4;
  localparam int PROD_W = FPS_W + PER_W;

  localparam logic [FPS_W-1:0] FPS_RESET = FPS_W'(30);
  localparam logic [PER_W-1:0] PER_RESET = PER_W'(5);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);

  localparam int DVR_W     = (CNT_W > FPS_W) ? CNT_W : FPS_W;
  localparam int DVD_W     = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_POP,
    ST_PUSH,
    ST_SEC,
    ST_SEC_WAIT,
    ST_AVG,
    ST_AVG_WAIT,
    ST_FIN
  } state_e;

endpackage

### hw/rtl/swbm_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Depends on nothing.
module swbm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 27,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/swbm_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on swbm_pkg and assert_macros.svh.
module swbm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swbm_pkg::SUM_W-1:0] dividend_i,
  input  logic [swbm_pkg::DVR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [swbm_pkg::SUM_W-1:0] quotient_o
);
  import swbm_pkg::*;
  `include "assert_macros.svh"

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVR_W-1:0]  rem_q, rem_d;
  logic [DVR_W-1:0]  dvr_q, dvr_d;
  logic [DVD_W-1:0]  quo_q, quo_d;

  logic [DVR_W:0]   r1, r2;
  logic [DVR_W-1:0] m1, m2;
  logic             b1, b2;

  always_comb begin
    r1 = {rem_q, quo_q[DVD_W-1]};
    b1 = (r1 >= {1'b0, dvr_q});
    m1 = b1 ? DVR_W'(r1 - {1'b0, dvr_q}) : r1[DVR_W-1:0];
    r2 = {m1, quo_q[DVD_W-2]};
    b2 = (r2 >= {1'b0, dvr_q});
    m2 = b2 ? DVR_W'(r2 - {1'b0, dvr_q}) : r2[DVR_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvr_d  = dvr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(DIV_STEPS);
      rem_d  = '0;
      dvr_d  = divisor_i;
      quo_d  = DVD_W'(dividend_i);
    end else if (busy_q) begin
      rem_d = m2;
      quo_d = {quo_q[DVD_W-3:0], b1, b2};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvr_q <= dvr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[SUM_W-1:0];

  `ASSERT_CLK(a_div_no_restart, clk_i, rst_ni, start_i |-> !busy_q, "divider restarted while busy")
  `ASSERT_CLK(a_div_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy_q), "divider done without run")
  `ASSERT_ALWAYS(a_div_done_idle, clk_i, done_o |-> !busy_q, "divider done while still busy")

endmodule

### hw/rtl/sliding_window_bitrate_monitor_unit.sv
// Top level of the sliding window bitrate monitor: window control, sum and output register.
// Depends on swbm_pkg, swbm_ram, swbm_div and assert_macros.svh.
//
//   Channel  Signals                                Direction
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i    in, always ready
//            cfg_data_i
//   in       in_valid_i in_ready_o frame_bytes_i    in
//   out      out_valid_o out_ready_i bitrate_bits_o out
//            bitrate_updated_o
//
// A frame passes from its transfer in to its result through window RAM read, pop and write
// when the window is full, or the write alone while it fills, then two passes of the
// two-bit-per-cycle divider, each from start to done. Without a whole second held, the
// second pass is skipped.
// A window limit shrink replaces read, pop and write by a read and a pop per dropped entry.
// Reset clears the control state; the window RAM needs no clearing.
// A new frame is taken while a result waits in the output register; a stalled output holds
// the block only when the next result is ready.
module sliding_window_bitrate_monitor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [swbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swbm_pkg::IN_W-1:0]       frame_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swbm_pkg::SUM_W-1:0]      bitrate_bits_o,
  output logic                            bitrate_updated_o
);
  import swbm_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic [FPS_W-1:0]  fps_q, fps_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [PTR_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  avg_q, avg_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic              shrink_q, shrink_d;
  logic [SIZE_W-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]  sec_q, sec_d;
  logic              upd_q, upd_d;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_bits_q, out_bits_d;
  logic              out_upd_q, out_upd_d;

  logic [FPS_W-1:0]  fps_eff;
  logic [PER_W-1:0]  per_eff;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  lim_c;
  logic [CNT_W:0]    slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [CNT_W-1:0]  held_dec;

  logic              in_xfer;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [SIZE_W-1:0] ram_rdata;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quotient;
  logic [DVR_W-1:0]  div_divisor;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    fps_eff = (fps_q == '0) ? FPS_W'(1) : fps_q;
    per_eff = (per_q == '0) ? PER_W'(1) : per_q;
    prod    = PROD_W'(fps_eff) * PROD_W'(per_eff);
    if (32'(prod) > 32'(MAX_WINDOW)) begin
      lim_c = CNT_W'(MAX_WINDOW);
    end else begin
      lim_c = CNT_W'(prod);
    end
    slot_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(held_q);
    if (slot_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
      slot = PTR_W'(slot_sum - (CNT_W + 1)'(MAX_WINDOW));
    end else begin
      slot = PTR_W'(slot_sum);
    end
    held_dec = held_q - CNT_W'(1);
  end

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (held_q >= lim_c) ? ST_READ : ST_PUSH;
        end
      end
      ST_READ: state_d = ST_POP;
      ST_POP: begin
        if (!shrink_q) begin
          state_d = ST_PUSH;
        end else if (held_dec > lim_q) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_SEC;
        end
      end
      ST_PUSH: state_d = ST_SEC;
      ST_SEC:  state_d = ST_SEC_WAIT;
      ST_SEC_WAIT: begin
        if (div_done) begin
          state_d = (div_quotient[CNT_W-1:0] == '0) ? ST_FIN : ST_AVG;
        end
      end
      ST_AVG: state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = sum_q;
    div_divisor  = DVR_W'(sec_q);
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: ram_re = 1'b1;
      ST_PUSH: ram_we = 1'b1;
      ST_SEC: begin
        div_start    = 1'b1;
        div_dividend = SUM_W'(held_q);
        div_divisor  = DVR_W'(fps_eff);
      end
      ST_AVG: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    fps_d       = fps_q;
    per_d       = per_q;
    oldest_d    = oldest_q;
    held_d      = held_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    lim_d       = lim_q;
    shrink_d    = shrink_q;
    bits_d      = bits_q;
    sec_d       = sec_q;
    upd_d       = upd_q;
    out_valid_d = out_valid_q;
    out_bits_d  = out_bits_q;
    out_upd_d   = out_upd_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FPS:    fps_d = cfg_data_i[FPS_W-1:0];
        CFG_PERIOD: per_d = cfg_data_i[PER_W-1:0];
        default: begin
        end
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          lim_d    = lim_c;
          shrink_d = (held_q > lim_c);
          bits_d   = {frame_bytes_i, 3'b000};
        end
      end
      ST_POP: begin
        sum_d  = sum_q - SUM_W'(ram_rdata);
        held_d = held_dec;
        if (oldest_q == PTR_W'(MAX_WINDOW - 1)) begin
          oldest_d = '0;
        end else begin
          oldest_d = oldest_q + PTR_W'(1);
        end
      end
      ST_PUSH: begin
        sum_d  = sum_q + SUM_W'(bits_q);
        held_d = held_q + CNT_W'(1);
      end
      ST_SEC_WAIT: begin
        if (div_done) begin
          sec_d = div_quotient[CNT_W-1:0];
          upd_d = 1'b0;
        end
      end
      ST_AVG_WAIT: begin
        if (div_done) begin
          avg_d = div_quotient;
          upd_d = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bits_d  = avg_q;
          out_upd_d   = upd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fps_q       <= FPS_RESET;
      per_q       <= PER_RESET;
      oldest_q    <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fps_q       <= fps_d;
      per_q       <= per_d;
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    shrink_q   <= shrink_d;
    bits_q     <= bits_d;
    sec_q      <= sec_d;
    upd_q      <= upd_d;
    out_bits_q <= out_bits_d;
    out_upd_q  <= out_upd_d;
  end

  swbm_ram #(
    .DEPTH(MAX_WINDOW),
    .WIDTH(SIZE_W)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i(bits_q),
    .re_i   (ram_re),
    .raddr_i(oldest_q),
    .rdata_o(ram_rdata)
  );

  swbm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  assign out_valid_o       = out_valid_q;
  assign bitrate_bits_o    = out_bits_q;
  assign bitrate_updated_o = out_upd_q;

  `ASSERT_CLK(a_held_bounded, clk_i, rst_ni, held_q <= CNT_W'(MAX_WINDOW), "window count overflow")
  `ASSERT_CLK(a_push_has_room, clk_i, rst_ni, (state_q == ST_PUSH) |-> (held_q < lim_q), "push into full window")
  `ASSERT_CLK(a_xfer_leaves_idle, clk_i, rst_ni, in_xfer |=> (state_q != ST_IDLE), "transfer not started")

endmodule

### test/tb_sliding_window_bitrate_monitor_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_bitrate_monitor_unit: directed table, then random
// frames over many window settings, checked against a bit-accurate window predictor.
// Depends on swbm_pkg and the RTL of the block only.
module tb_sliding_window_bitrate_monitor_unit;
  import swbm_pkg::*;

  localparam int HOLD_OFF   = 400;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL       = 200;
  localparam int RAND_SETS  = 16;
  localparam int DIR_ROWS   = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  typedef enum logic { ROW_FRAME, ROW_WRITE } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [IN_W-1:0]       fbytes;
    bit                    typed;
    logic [SUM_W-1:0]      rate;
    logic                  fresh;
  } stim_row_t;

  typedef struct {
    logic [SUM_W-1:0] rate;
    logic             fresh;
  } rate_exp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [IN_W-1:0]       frame_bytes;
  logic                  out_valid;
  logic                  out_ready;
  logic [SUM_W-1:0]      bitrate_bits;
  logic                  bitrate_updated;

  logic [SIZE_W-1:0] win_sizes [MAX_WINDOW];
  logic [PTR_W-1:0]  win_head;
  int unsigned       win_count;
  logic [SUM_W-1:0]  win_sum;
  logic [SUM_W-1:0]  rate_avg;
  logic [FPS_W-1:0]  cfg_fps;
  logic [PER_W-1:0]  cfg_secs;

  rate_exp_t rate_q[$];
  int        mismatches;
  int        frames_in;
  int        results_out;
  int        reg_writes;
  int        max_shrink;
  int        max_held;
  int        idle_cycles;
  bit        hold_off_req;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000000, 1'b1, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hFFFFFF, 1'b1, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_FPS,      7'd0,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_PERIOD,   7'd0,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hFFFFFF, 1'b1, 37'd134217720, 1'b1},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000000, 1'b1, 37'd0,         1'b1},
    '{ROW_WRITE, CFG_SPARE_LO, 7'h7F,  24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_SPARE_HI, 7'h00,  24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000001, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_FPS,      7'd127, 24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_PERIOD,   7'd15,  24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hAAAAAA, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h555555, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_FPS,      7'd2,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_PERIOD,   7'h72,  24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hC00000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hFFFFFF, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h800000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000001, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hFFFFFF, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_FPS,      7'd120, 24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_WRITE, CFG_PERIOD,   7'd8,   24'h000000, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h123456, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'hFEDCBA, 1'b0, 37'd0,         1'b0},
    '{ROW_FRAME, CFG_FPS,      7'd0,   24'h000000, 1'b0, 37'd0,         1'b0}
  };

  sliding_window_bitrate_monitor_unit DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .frame_bytes_i     (frame_bytes),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .bitrate_bits_o    (bitrate_bits),
    .bitrate_updated_o (bitrate_updated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_oldest();
    win_sum   = win_sum - SUM_W'(win_sizes[win_head]);
    win_head  = win_head + 1'b1;
    win_count = win_count - 1;
  endfunction

  function automatic void predict_rate(input logic [IN_W-1:0] fb,
                                       output logic [SUM_W-1:0] rate, output logic fresh);
    int unsigned       fps_eff;
    int unsigned       limit;
    int unsigned       secs;
    int                dropped;
    logic [SIZE_W-1:0] bits;
    bits    = {fb, 3'b000};
    fps_eff = (cfg_fps == '0) ? 1 : cfg_fps;
    limit   = fps_eff * ((cfg_secs == '0) ? 1 : cfg_secs);
    if (limit > MAX_WINDOW) begin
      limit = MAX_WINDOW;
    end
    if (win_count > limit) begin
      dropped = win_count - limit;
      while (win_count > limit) begin
        drop_oldest();
      end
      if (dropped > max_shrink) begin
        max_shrink = dropped;
      end
    end else begin
      if (win_count == limit) begin
        drop_oldest();
      end
      win_sizes[win_head + PTR_W'(win_count)] = bits;
      win_sum   = win_sum + SUM_W'(bits);
      win_count = win_count + 1;
    end
    if (win_count > max_held) begin
      max_held = win_count;
    end
    secs  = win_count / fps_eff;
    fresh = 1'b0;
    if (secs >= 1) begin
      rate_avg = SUM_W'(win_sum / SUM_W'(secs));
      fresh    = 1'b1;
    end
    rate = rate_avg;
  endfunction

  task automatic send_frame(input logic [IN_W-1:0] fb, input bit typed,
                            input logic [SUM_W-1:0] rate, input logic fresh);
    rate_exp_t        e;
    logic [SUM_W-1:0] p_rate;
    logic             p_fresh;
    cfg_valid   <= 1'b0;
    in_valid    <= 1'b1;
    frame_bytes <= fb;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_rate(fb, p_rate, p_fresh);
    e.rate  = typed ? rate : p_rate;
    e.fresh = typed ? fresh : p_fresh;
    rate_q.push_back(e);
    frames_in++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_FPS: begin
        cfg_fps = data[FPS_W-1:0];
      end
      CFG_PERIOD: begin
        cfg_secs = data[PER_W-1:0];
      end
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (rate_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic pause_sender(input int cycles);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin : receiver
    logic [31:0] rx_cyc;
    rx_cyc = '0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        case (rx_cyc[9:8])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 9) < 7);
          2'd2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_cyc % 7) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    rate_exp_t e;
    if (rst_n && out_valid && out_ready) begin
      results_out++;
      if (rate_q.size() == 0) begin
        $error("Result transfer with no frame outstanding: bitrate_bits %0d", bitrate_bits);
        mismatches++;
      end else begin
        e = rate_q.pop_front();
        if (bitrate_bits !== e.rate) begin
          $error("bitrate_bits: expected %0d, actual %0d", e.rate, bitrate_bits);
          mismatches++;
        end
        if (bitrate_updated !== e.fresh) begin
          $error("bitrate_updated: expected %0d, actual %0d", e.fresh, bitrate_updated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer.", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int               n_items;
    int               burst_left;
    int unsigned      limit;
    logic [FPS_W-1:0] fps_w;
    logic [PER_W-1:0] per_w;
    logic [IN_W-1:0]  fb;

    mismatches   = 0;
    frames_in    = 0;
    results_out  = 0;
    reg_writes   = 0;
    max_shrink   = 0;
    max_held     = 0;
    idle_cycles  = 0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    foreach (win_sizes[i]) win_sizes[i] = '0;
    win_head  = '0;
    win_count = 0;
    win_sum   = '0;
    rate_avg  = '0;
    cfg_fps   = FPS_RESET;
    cfg_secs  = PER_RESET;

    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    frame_bytes <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        wait_results();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_frame(dir_rows[r].fbytes, dir_rows[r].typed, dir_rows[r].rate, dir_rows[r].fresh);
      end
    end

    for (int ph = 0; ph < RAND_SETS; ph++) begin
      case (ph)
        0: begin
          fps_w = 7'd100;
          per_w = 4'd7;
        end
        1: begin
          fps_w = 7'd120;
          per_w = 4'd5;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: fps_w = 7'd0;
            1: fps_w = 7'd1;
            2: fps_w = 7'd127;
            default: fps_w = FPS_W'($urandom_range(2, 8));
          endcase
          if (fps_w > 8) begin
            per_w = PER_W'($urandom_range(0, 1));
          end else begin
            case ($urandom_range(0, 3))
              0: per_w = 4'd0;
              1: per_w = 4'd15;
              default: per_w = PER_W'($urandom_range(1, 8));
            endcase
          end
        end
      endcase
      limit = ((fps_w == 0) ? 1 : fps_w) * ((per_w == 0) ? 1 : per_w);
      if (limit > MAX_WINDOW) begin
        limit = MAX_WINDOW;
      end
      if (ph == 0) begin
        n_items = limit + $urandom_range(8, 30);
      end else begin
        n_items = $urandom_range(8, 16);
      end

      wait_results();
      if ($urandom_range(0, 2) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DATA_W'($urandom));
      end
      write_reg(CFG_FPS, fps_w);
      write_reg(CFG_PERIOD, {CFG_DATA_W'($urandom_range(0, 7)) << PER_W} | CFG_DATA_W'(per_w));

      for (int i = 0; i < n_items; i++) begin
        if (ph == 0 && i == 100) begin
          hold_off_req = 1'b1;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!(ph == 0 && i >= 100 && i < 160) && $urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 40));
          end
        end
        case ($urandom_range(0, 9))
          0: fb = '0;
          1: fb = '1;
          2, 3: fb = IN_W'($urandom);
          4: fb = IN_W'(12582912);
          default: fb = IN_W'($urandom_range(1000, 200000));
        endcase
        send_frame(fb, 1'b0, '0, 1'b0);
        burst_left--;
      end
    end

    wait_results();
    repeat (TAIL) @(posedge clk);

    $display("Run covered %0d frames and %0d register writes over %0d window settings.",
             frames_in, reg_writes, RAND_SETS + 5);
    $display("Window held up to %0d entries and shrank by up to %0d; %0d results checked.",
             max_held, max_shrink, results_out);
    if (mismatches == 0 && rate_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
